FILE: rtl/core/scan_channel_averager_assert.svh
// Assertion helpers for the scan channel averager checker.
// Each macro expects clk and rst_n in scope.
`ifndef SCAN_CHANNEL_AVERAGER_ASSERT_SVH
`define SCAN_CHANNEL_AVERAGER_ASSERT_SVH

// Same-cycle implication.
`define SCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sca_pkg.sv
`default_nettype none

package sca_pkg;

  localparam int MAX_POSITIONS_DEF = 16;
  localparam int SAMPLE_BITS_DEF   = 12;

  localparam int SAMPLE_W   = 12;
  localparam int IN_DATA_W  = 16;
  localparam int CHAN_W     = 5;
  localparam int POS_W      = 4;
  localparam int NPOS_W     = 5;
  localparam int ROUND_W    = 8;
  localparam int ACC_W      = 20;
  localparam int MV_W       = 12;
  localparam int OUT_DATA_W = 32;
  localparam int SEQ_W      = 40;
  localparam int MASK_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int PROD_W     = 32;
  localparam int DIVR_W     = 20;

  localparam logic [ACC_W-1:0]    ACC_MAX    = {ACC_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
  localparam logic [MV_W-1:0]     VREF_MV    = 12'd3300;
  localparam logic [CHAN_W-1:0]   NUM_CHANNELS = 5'd18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_POSITIONS = 3'd0,
    CFG_ROUNDS        = 3'd1,
    CFG_SEQUENCE_LOW  = 3'd2,
    CFG_SEQUENCE_HIGH = 3'd3,
    CFG_REPORT_MASK   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_DIV_AVG,
    ST_DIV_MV,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // accumulate the sample on the input channel
    logic scan;     // note the walk position as last reported if enabled
    logic step;     // advance the walk position, wrapping at the end
    logic div_avg;  // start the mean division for the walk position
    logic div_mv;   // start the millivolt division
    logic emit;     // load the output register
    logic clear;    // clear all accumulators
  } sca_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic buf_done;     // the next sample completes the buffer
    logic walk_end;     // walk position is the last scan position
    logic pos_enabled;  // walk position's channel is reported
    logic div_done;     // divider result is ready
    logic out_free;     // output register can take a result
  } sca_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/scan_channel_averager.sv
`default_nettype none

// Channel  Direction  Handshake                 Payload
// in_      slave      in_tvalid / in_tready     in_tdata: sample [11:0]
// out_     master     out_tvalid / out_tready   out_tdata, out_tuser: channel, out_tlast
// cfg_     slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A sample that does not end a buffer keeps in_tready high, so samples may come back to back.
// At the end of a buffer in_tready drops for the walk: a mask scan over the scan positions,
// a step past each unreported position, and for each reported position a mean and then a
// millivolt division on the shared restoring divider, then a clear.
// Synchronous reset clears all accumulators at once; the output register lets the walk run
// one result ahead of a stalled sink. cfg_ready is always high.
module scan_channel_averager #(
  parameter int MAX_POSITIONS = sca_pkg::MAX_POSITIONS_DEF,
  parameter int SAMPLE_BITS   = sca_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [sca_pkg::IN_DATA_W-1:0]    in_tdata,   // [11:0] sample
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [sca_pkg::OUT_DATA_W-1:0]        out_tdata,  // [3:0] position, [15:4] average,
                                                            // [27:16] millivolts
  output logic [sca_pkg::CHAN_W-1:0]            out_tuser,  // [4:0] channel
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sca_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sca_pkg::sca_cmd_t  cmd;
  sca_pkg::sca_stat_t stat;

  assign cfg_ready = 1'b1;

  sca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sca_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/core/sca_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sca_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [sca_pkg::PROD_W-1:0]   dividend,
  input  wire logic [sca_pkg::DIVR_W-1:0]   divisor,
  output logic                              done,
  output logic [sca_pkg::PROD_W-1:0]        quotient
);

  localparam int PW    = sca_pkg::PROD_W;
  localparam int DW    = sca_pkg::DIVR_W;
  localparam int CNT_W = $clog2(PW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(PW - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [PW-1:0]    quo_r;
  logic [DW-1:0]    dsr_r;

  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;
  logic [DW-1:0]    rem_nxt;

  assign trial   = {rem_r, quo_r[PW-1]};
  assign diff    = trial - {1'b0, dsr_r};
  assign fits    = (trial >= {1'b0, dsr_r});
  assign rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[PW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/core/sca_datapath.sv
`default_nettype none

module sca_datapath #(
  parameter int MAX_POSITIONS = sca_pkg::MAX_POSITIONS_DEF,
  parameter int SAMPLE_BITS   = sca_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire sca_pkg::sca_cmd_t                cmd,
  output sca_pkg::sca_stat_t                    stat,
  input  wire logic [sca_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                             cfg_wr,
  input  wire logic [sca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sca_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [sca_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [sca_pkg::CHAN_W-1:0]            out_tuser,
  output logic                                  out_tlast
);

  localparam int SW     = sca_pkg::SAMPLE_W;
  localparam int AW     = sca_pkg::ACC_W;
  localparam int PW     = sca_pkg::POS_W;
  localparam int NW     = sca_pkg::NPOS_W;
  localparam int RW     = sca_pkg::ROUND_W;
  localparam int CW     = sca_pkg::CHAN_W;
  localparam int QW     = sca_pkg::PROD_W;
  localparam int DW     = sca_pkg::DIVR_W;
  localparam int IDX_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int USED_BITS = (SAMPLE_BITS < SW) ? SAMPLE_BITS : SW;
  localparam logic [SW-1:0] SAMPLE_MASK = SW'((32'd1 << USED_BITS) - 32'd1);
  localparam logic [NW-1:0] MAX_NPOS    = NW'(MAX_POSITIONS);

  // Configuration registers
  logic [NW-1:0]              num_pos_r;
  logic [RW-1:0]              rounds_r;
  logic [sca_pkg::SEQ_W-1:0]  seq_low_r;
  logic [sca_pkg::SEQ_W-1:0]  seq_high_r;
  logic [sca_pkg::MASK_W-1:0] mask_r;

  // Accumulators; an entry without its valid bit reads as zero.
  logic [AW-1:0]              acc_r [MAX_POSITIONS];
  logic [MAX_POSITIONS-1:0]   acc_valid_r;

  logic [PW-1:0]              pos_r;
  logic [RW-1:0]              round_r;
  logic [PW-1:0]              walk_r;
  logic [PW-1:0]              last_r;

  logic [QW-1:0]              prod_r;
  logic                       mode_mv_r;
  logic [SW-1:0]              avg_r;
  logic [sca_pkg::MV_W-1:0]   mv_r;

  logic                       out_valid_r;
  logic [PW-1:0]              out_pos_r;
  logic [SW-1:0]              out_avg_r;
  logic [sca_pkg::MV_W-1:0]   out_mv_r;
  logic [CW-1:0]              out_chan_r;
  logic                       out_last_r;

  logic [NW-1:0]              npos;
  logic [RW-1:0]              nr;
  logic [SW-1:0]              sample;
  logic [IDX_W-1:0]           rd_idx;
  logic [AW-1:0]              rd_val;
  logic [AW:0]                sum;
  logic [AW-1:0]              acc_nxt;
  logic                       pos_wrap;
  logic                       round_wrap;
  logic [sca_pkg::SEQ_W-1:0]  seq_word;
  logic [CW-1:0]              walk_chan;
  logic [31:0]                mask_ext;
  logic                       walk_end;
  logic                       pos_enabled;
  logic                       out_free;
  logic                       div_start;
  logic [QW-1:0]              div_dividend;
  logic [DW-1:0]              div_divisor;
  logic [DW-1:0]              mv_divisor;
  logic                       div_done;
  logic [QW-1:0]              div_quo;

  always_comb begin
    npos = num_pos_r;
    if (npos == '0) begin
      npos = NW'(1);
    end
    if (npos > MAX_NPOS) begin
      npos = MAX_NPOS;
    end
  end

  assign nr     = (rounds_r == '0) ? RW'(1) : rounds_r;
  assign sample = in_tdata[SW-1:0] & SAMPLE_MASK;

  // One read port, shared between accumulation and the walk.
  assign rd_idx  = cmd.div_avg ? walk_r[IDX_W-1:0] : pos_r[IDX_W-1:0];
  assign rd_val  = acc_valid_r[rd_idx] ? acc_r[rd_idx] : '0;
  assign sum     = {1'b0, rd_val} + {{(AW+1-SW){1'b0}}, sample};
  assign acc_nxt = sum[AW] ? sca_pkg::ACC_MAX : sum[AW-1:0];

  assign pos_wrap   = !(({1'b0, pos_r} + NW'(1)) < npos);
  assign round_wrap = !(({1'b0, round_r} + (RW+1)'(1)) < {1'b0, nr});

  assign seq_word    = walk_r[PW-1] ? seq_high_r : seq_low_r;
  assign walk_chan   = seq_word[walk_r[2:0] * CW +: CW];
  assign mask_ext    = {{(32-sca_pkg::MASK_W){1'b0}}, mask_r};
  assign pos_enabled = (walk_chan < sca_pkg::NUM_CHANNELS) && mask_ext[walk_chan];
  assign walk_end    = ({1'b0, walk_r} == (npos - NW'(1)));
  assign out_free    = !out_valid_r || out_tready;

  // nr * 4095 as nr * 4096 - nr
  assign mv_divisor   = {nr, 12'b0} - {{(DW-RW){1'b0}}, nr};
  assign div_start    = cmd.div_avg || cmd.div_mv;
  assign div_dividend = cmd.div_mv ? prod_r : {{(QW-AW){1'b0}}, rd_val};
  assign div_divisor  = cmd.div_mv ? mv_divisor : {{(DW-RW){1'b0}}, nr};

  sca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pos_r  <= NW'(1);
      rounds_r   <= RW'(1);
      seq_low_r  <= '0;
      seq_high_r <= '0;
      mask_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        sca_pkg::CFG_NUM_POSITIONS: num_pos_r  <= cfg_data[NW-1:0];
        sca_pkg::CFG_ROUNDS:        rounds_r   <= cfg_data[RW-1:0];
        sca_pkg::CFG_SEQUENCE_LOW:  seq_low_r  <= cfg_data[sca_pkg::SEQ_W-1:0];
        sca_pkg::CFG_SEQUENCE_HIGH: seq_high_r <= cfg_data[sca_pkg::SEQ_W-1:0];
        sca_pkg::CFG_REPORT_MASK:   mask_r     <= cfg_data[sca_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc_r[pos_r[IDX_W-1:0]] <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= '0;
      pos_r       <= '0;
      round_r     <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        acc_valid_r <= '0;
      end else if (cmd.accept) begin
        acc_valid_r[pos_r[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.accept) begin
        if (pos_wrap) begin
          pos_r <= '0;
          round_r <= round_wrap ? '0 : round_r + RW'(1);
        end else begin
          pos_r <= pos_r + PW'(1);
        end
      end
      if (cmd.step) begin
        walk_r <= walk_end ? '0 : walk_r + PW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && pos_enabled) begin
      last_r <= walk_r;
    end
    if (cmd.div_avg) begin
      prod_r    <= QW'(rd_val * 12'd3300);
      mode_mv_r <= 1'b0;
    end else if (cmd.div_mv) begin
      mode_mv_r <= 1'b1;
    end
    if (div_done && !mode_mv_r) begin
      avg_r <= (div_quo > QW'(sca_pkg::FULL_SCALE)) ? sca_pkg::FULL_SCALE : div_quo[SW-1:0];
    end
    if (div_done && mode_mv_r) begin
      mv_r <= (div_quo > QW'(sca_pkg::VREF_MV)) ? sca_pkg::VREF_MV
                                                : div_quo[sca_pkg::MV_W-1:0];
    end
    if (cmd.emit) begin
      out_pos_r  <= walk_r;
      out_avg_r  <= avg_r;
      out_mv_r   <= mv_r;
      out_chan_r <= walk_chan;
      out_last_r <= (walk_r == last_r);
    end
  end

  assign stat.buf_done    = pos_wrap && round_wrap;
  assign stat.walk_end    = walk_end;
  assign stat.pos_enabled = pos_enabled;
  assign stat.div_done    = div_done;
  assign stat.out_free    = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sca_pkg::OUT_DATA_W - PW - SW - sca_pkg::MV_W){1'b0}},
                       out_mv_r, out_avg_r, out_pos_r};
  assign out_tuser  = out_chan_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/sca_ctrl.sv
`default_nettype none

module sca_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire sca_pkg::sca_stat_t  stat,
  output sca_pkg::sca_cmd_t        cmd
);

  sca_pkg::state_t state_r;
  sca_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sca_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sca_pkg::ST_IDLE: begin
        if (in_tvalid && stat.buf_done) begin
          state_nxt = sca_pkg::ST_SCAN;
        end
      end
      sca_pkg::ST_SCAN: begin
        if (stat.walk_end) begin
          state_nxt = sca_pkg::ST_WALK;
        end
      end
      sca_pkg::ST_WALK: begin
        if (stat.pos_enabled) begin
          state_nxt = sca_pkg::ST_DIV_AVG;
        end else if (stat.walk_end) begin
          state_nxt = sca_pkg::ST_CLEAR;
        end
      end
      sca_pkg::ST_DIV_AVG: begin
        if (stat.div_done) begin
          state_nxt = sca_pkg::ST_DIV_MV;
        end
      end
      sca_pkg::ST_DIV_MV: begin
        if (stat.div_done) begin
          state_nxt = sca_pkg::ST_EMIT;
        end
      end
      sca_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = stat.walk_end ? sca_pkg::ST_CLEAR : sca_pkg::ST_WALK;
        end
      end
      sca_pkg::ST_CLEAR: state_nxt = sca_pkg::ST_IDLE;
      default:           state_nxt = sca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      sca_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      sca_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        cmd.step = 1'b1;
      end
      sca_pkg::ST_WALK: begin
        cmd.div_avg = stat.pos_enabled;
        cmd.step    = !stat.pos_enabled;
      end
      sca_pkg::ST_DIV_AVG: cmd.div_mv = stat.div_done;
      sca_pkg::ST_DIV_MV:  ;
      sca_pkg::ST_EMIT: begin
        cmd.emit = stat.out_free;
        cmd.step = stat.out_free;
      end
      sca_pkg::ST_CLEAR: cmd.clear = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/sca_checker.sv
`default_nettype none

`include "scan_channel_averager_assert.svh"

module sca_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [sca_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tlast
);

  `SCA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `SCA_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "stalled result changed")
  `SCA_ASSERT_NOW(a_mv_range, out_tvalid, out_tdata[27:16] <= 12'd3300, "millivolts above 3300")
  // A result that is not the last of its run is taken while the walk still blocks samples.
  `SCA_ASSERT_NEXT(a_walk_blocks, out_tvalid && out_tready && !out_tlast, !in_tready, "sample taken mid-walk")

endmodule

bind scan_channel_averager sca_checker u_checker (.*);

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sca_pkg::*;

  localparam int RAND_ITEMS       = 180;
  // A full walk over sixteen reported positions, each divided twice, plus the mask scan.
  localparam int WALK_CYCLES      = 1200;
  localparam int TAIL_CYCLES      = 24;
  localparam int IDLE_LIMIT       = 6000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [POS_W-1:0]    position;
    logic [SAMPLE_W-1:0] average;
    logic [MV_W-1:0]     millivolts;
    logic                final_flag;
  } avg_result_t;

  typedef enum {ROW_WRITE, ROW_SAMPLE, ROW_CHECKED} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic [SAMPLE_W-1:0]   sample;
    avg_result_t           want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [CHAN_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  scan_channel_averager uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the registers and the accumulation state.
  logic [NPOS_W-1:0]  num_positions_r = 5'd1;
  logic [ROUND_W-1:0] rounds_r        = 8'd1;
  logic [SEQ_W-1:0]   seq_low_r       = '0;
  logic [SEQ_W-1:0]   seq_high_r      = '0;
  logic [MASK_W-1:0]  mask_r          = '0;
  logic [ACC_W-1:0]   acc [MAX_POSITIONS_DEF] = '{default: '0};
  logic [POS_W-1:0]   next_pos        = '0;
  logic [ROUND_W-1:0] done_rounds     = '0;

  avg_result_t pending_results[$];
  avg_result_t buffer_results[$];
  stim_row_t   stim_rows[$];

  bit quiet         = 1'b0;
  int settle_cycles = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;
  int n_samples     = 0;
  int n_results     = 0;
  int n_buffers     = 0;
  int n_writes      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned scan_length();
    int unsigned n;
    n = num_positions_r;
    if (n == 0) n = 1;
    if (n > MAX_POSITIONS_DEF) n = MAX_POSITIONS_DEF;
    return n;
  endfunction

  function automatic int unsigned round_target();
    return (rounds_r == 0) ? 1 : rounds_r;
  endfunction

  function automatic logic [CHAN_W-1:0] channel_at(int unsigned p);
    logic [SEQ_W-1:0] word;
    word = (p < 8) ? seq_low_r : seq_high_r;
    return word[(p % 8) * CHAN_W +: CHAN_W];
  endfunction

  function automatic bit is_reported(int unsigned p);
    logic [CHAN_W-1:0] ch;
    ch = channel_at(p);
    if (ch >= NUM_CHANNELS) return 1'b0;
    return mask_r[ch];
  endfunction

  // Adds one sample to its position; on a completed buffer fills buffer_results and returns 1.
  function automatic bit accumulate_sample(logic [SAMPLE_W-1:0] s);
    int unsigned pos;
    int unsigned npos;
    int unsigned nr;
    int unsigned sum;
    int unsigned last_p;
    longint unsigned total;
    longint unsigned avg;
    longint unsigned mv;
    avg_result_t r;
    buffer_results.delete();
    pos  = next_pos;
    npos = scan_length();
    nr   = round_target();
    sum  = acc[pos] + s;
    acc[pos] = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
    if (pos + 1 < npos) begin
      next_pos = pos + 1;
      return 1'b0;
    end
    next_pos = '0;
    if (done_rounds + 1 < nr) begin
      done_rounds = done_rounds + 1;
      return 1'b0;
    end
    done_rounds = '0;
    last_p = npos;
    for (int unsigned p = 0; p < npos; p++) begin
      if (is_reported(p)) last_p = p;
    end
    for (int unsigned p = 0; p < npos; p++) begin
      if (is_reported(p)) begin
        total = acc[p];
        avg = total / nr;
        if (avg > FULL_SCALE) avg = FULL_SCALE;
        mv = (total * VREF_MV) / (FULL_SCALE * nr);
        if (mv > VREF_MV) mv = VREF_MV;
        r.channel    = channel_at(p);
        r.position   = p[POS_W-1:0];
        r.average    = avg[SAMPLE_W-1:0];
        r.millivolts = mv[MV_W-1:0];
        r.final_flag = (p == last_p);
        buffer_results.push_back(r);
      end
    end
    foreach (acc[i]) acc[i] = '0;
    return 1'b1;
  endfunction

  function automatic logic [SEQ_W-1:0] rand_seq(bit in_range);
    logic [SEQ_W-1:0] word;
    word = {8'($urandom), $urandom};
    if (in_range) begin
      for (int p = 0; p < 8; p++) word[p * CHAN_W +: CHAN_W] = $urandom_range(0, NUM_CHANNELS - 1);
    end
    return word;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FULL_SCALE;
      default: return $urandom_range(0, FULL_SCALE);
    endcase
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row.kind   = ROW_WRITE;
    row.index  = idx;
    row.data   = value;
    row.sample = '0;
    row.want   = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_sample(logic [SAMPLE_W-1:0] s);
    stim_row_t row;
    row.kind   = ROW_SAMPLE;
    row.index  = '0;
    row.data   = '0;
    row.sample = s;
    row.want   = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_checked(logic [SAMPLE_W-1:0] s, avg_result_t want);
    stim_row_t row;
    row.kind   = ROW_CHECKED;
    row.index  = '0;
    row.data   = '0;
    row.sample = s;
    row.want   = want;
    stim_rows.push_back(row);
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) $display("mismatch: %s", what);
  endtask

  // Waits until every expected result has arrived and the walk has had time to finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
    settle_cycles = 0;
  endtask

  // Leaves cfg_valid high; the next sample transaction lowers it.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    n_writes++;
    case (idx)
      CFG_NUM_POSITIONS: num_positions_r = value[NPOS_W-1:0];
      CFG_ROUNDS:        rounds_r        = value[ROUND_W-1:0];
      CFG_SEQUENCE_LOW:  seq_low_r       = value[SEQ_W-1:0];
      CFG_SEQUENCE_HIGH: seq_high_r      = value[SEQ_W-1:0];
      CFG_REPORT_MASK:   mask_r          = value[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input avg_result_t want);
    int unsigned w;
    bit completed;
    w = quiet ? 0 : $urandom_range(0, 10);
    cfg_valid <= 1'b0;
    if (w != 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(s);
    do @(posedge clk); while (!in_tready);
    n_samples++;
    completed = accumulate_sample(s);
    if (completed) n_buffers++;
    // A buffer with nothing to report still runs the mask scan and the clear.
    settle_cycles = (completed && buffer_results.size() == 0) ? WALK_CYCLES : TAIL_CYCLES;
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (buffer_results[i]) pending_results.push_back(buffer_results[i]);
    end
  endtask

  initial begin : sink
    int unsigned w;
    wait (rst_n);
    @(posedge clk);
    forever begin
      w = quiet ? 0 : $urandom_range(0, 10);
      if (w != 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    avg_result_t got;
    avg_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.channel    = out_tuser;
      got.position   = out_tdata[3:0];
      got.average    = out_tdata[15:4];
      got.millivolts = out_tdata[27:16];
      got.final_flag = out_tlast;
      n_results++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result ch %0d pos %0d avg %0d mv %0d last %0b",
                                got.channel, got.position, got.average, got.millivolts,
                                got.final_flag));
      end else begin
        want = pending_results.pop_front();
        if (got.channel !== want.channel || got.position !== want.position ||
            got.average !== want.average || got.millivolts !== want.millivolts ||
            got.final_flag !== want.final_flag) begin
          note_mismatch($sformatf(
              "expected ch %0d pos %0d avg %0d mv %0d last %0b, got ch %0d pos %0d avg %0d mv %0d last %0b",
              want.channel, want.position, want.average, want.millivolts, want.final_flag,
              got.channel, got.position, got.average, got.millivolts, got.final_flag));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned rand_items;
    int unsigned count;
    int unsigned buf_len;
    logic [NPOS_W-1:0] npos;
    bit in_cfg;

    // After reset channel 0 sits at every position but nothing is enabled.
    add_sample(12'd4095);
    add_write(CFG_REPORT_MASK, 40'h1);
    add_checked(12'd4095, '{5'd0, 4'd0, 12'd4095, 12'd3300, 1'b1});
    add_checked(12'd0, '{5'd0, 4'd0, 12'd0, 12'd0, 1'b1});
    // Four positions over two rounds: channels 17, 3, 20 and 5, of which 17 and 3 are reported.
    add_write(CFG_NUM_POSITIONS, 4);
    add_write(CFG_ROUNDS, 2);
    add_write(CFG_SEQUENCE_LOW, (5 << 15) | (20 << 10) | (3 << 5) | 17);
    add_write(CFG_SEQUENCE_HIGH, 40'hFF_FFFF_FFFF);
    add_write(CFG_REPORT_MASK, (1 << 17) | (1 << 3) | 1);
    add_sample(12'hAAA);
    add_sample(12'h555);
    add_sample(12'd4095);
    add_sample(12'd1);
    add_sample(12'd4095);
    add_sample(12'd4095);
    add_sample(12'd0);
    add_sample(12'd2);
    // Shrink the sequence while the scan stands at position 5.
    add_write(CFG_NUM_POSITIONS, 8);
    add_write(CFG_ROUNDS, 1);
    for (int i = 1; i <= 5; i++) add_sample(12'(i * 100));
    add_write(CFG_NUM_POSITIONS, 2);
    add_sample(12'd600);
    // Lower rounds after three full rounds; the mean then runs past full scale.
    add_write(CFG_NUM_POSITIONS, 1);
    add_write(CFG_ROUNDS, 4);
    for (int i = 0; i < 3; i++) add_sample(12'd4095);
    add_write(CFG_ROUNDS, 1);
    add_checked(12'd4095, '{5'd17, 4'd0, 12'd4095, 12'd3300, 1'b1});
    add_write(CFG_NUM_POSITIONS, 0);
    add_write(CFG_ROUNDS, 0);
    add_sample(12'd1234);
    // A buffer with no enabled channel, after a write to an index that does not exist.
    add_write(CFG_REPORT_MASK, 0);
    add_write(CFG_UNUSED, 40'hFF_FFFF_FFFF);
    add_write(CFG_NUM_POSITIONS, 2);
    add_sample(12'd7);
    add_sample(12'd9);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_cfg = 1'b0;
    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_WRITE: begin
          if (!in_cfg) settle();
          in_cfg = 1'b1;
          cfg_write(stim_rows[i].index, stim_rows[i].data);
        end
        default: begin
          in_cfg = 1'b0;
          send_sample(stim_rows[i].sample, stim_rows[i].kind == ROW_CHECKED, stim_rows[i].want);
        end
      endcase
    end

    phase = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      settle();
      if (phase == 0) begin
        // Every position of the longest sequence reported in one buffer.
        cfg_write(CFG_NUM_POSITIONS, MAX_POSITIONS_DEF);
        cfg_write(CFG_ROUNDS, 1);
        cfg_write(CFG_SEQUENCE_LOW, rand_seq(1'b1));
        cfg_write(CFG_SEQUENCE_HIGH, rand_seq(1'b1));
        cfg_write(CFG_REPORT_MASK, CFG_DATA_W'({MASK_W{1'b1}}));
      end else begin
        case ($urandom_range(0, 9))
          0:       npos = 5'd0;
          1:       npos = 5'd31;
          2:       npos = 5'd16;
          default: npos = $urandom_range(1, 5);
        endcase
        cfg_write(CFG_NUM_POSITIONS, npos);
        cfg_write(CFG_ROUNDS, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3));
        if ($urandom_range(0, 1)) cfg_write(CFG_SEQUENCE_LOW, rand_seq($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) cfg_write(CFG_SEQUENCE_HIGH, rand_seq($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) begin
          cfg_write(CFG_REPORT_MASK, ($urandom_range(0, 3) == 0) ?
                    CFG_DATA_W'({MASK_W{1'b1}}) : CFG_DATA_W'($urandom));
        end
      end
      quiet = ($urandom_range(0, 3) == 0);
      buf_len = scan_length() * round_target();
      count = buf_len * ((buf_len > 16) ? 1 : $urandom_range(1, 2));
      // Sometimes stop mid-buffer so the next settings meet a partly filled scan.
      if ($urandom_range(0, 2) == 0) count += $urandom_range(1, buf_len);
      repeat (count) send_sample(rand_sample(), 1'b0, '0);
      rand_items += count;
      phase++;
    end

    // The deepest average on a single position.
    settle();
    cfg_write(CFG_NUM_POSITIONS, 1);
    cfg_write(CFG_ROUNDS, 255);
    cfg_write(CFG_REPORT_MASK, CFG_DATA_W'({MASK_W{1'b1}}));
    quiet = 1'b0;
    repeat (255) send_sample(rand_sample(), 1'b0, '0);

    settle_cycles = WALK_CYCLES;
    settle();

    $display("%0d samples in %0d completed buffers over %0d setting phases, %0d register writes",
             n_samples, n_buffers, phase + 2, n_writes);
    $display("%0d results compared, %0d mismatches", n_results, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
